// ===== rtl/incremental_all_pairs_distance_update_unit_assert.svh =====
// Assertion macros used by the apdu_checker file.
`ifndef INCREMENTAL_ALL_PAIRS_DISTANCE_UPDATE_UNIT_ASSERT_SVH
`define INCREMENTAL_ALL_PAIRS_DISTANCE_UPDATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define APDU_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define APDU_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

// ===== rtl/apdu_pkg.sv =====
// ----------------------------------------------------------------------------
// apdu_pkg
// Types, widths and helpers for the all-pairs distance update unit.
// ----------------------------------------------------------------------------
package apdu_pkg;

    localparam int DIST_W = 24;
    localparam int LEN_W  = 16;
    localparam int SUM_W  = 39;
    localparam int CNT_W  = 9;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Request kinds carried on req_type.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_ROAD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LAB,
        ST_WAB,
        ST_LBA,
        ST_WBA,
        ST_RIA,
        ST_RIB,
        ST_RIBC,
        ST_PIJ,
        ST_PBJ,
        ST_PAJ,
        ST_PC1,
        ST_PC2,
        ST_SRD,
        ST_SACC,
        ST_DONE
    } apdu_state_t;

    // Sum of two distances and a road length, saturated at the store maximum.
    function automatic logic [DIST_W-1:0] sat_add3(input logic [DIST_W-1:0] x,
                                                   input logic [LEN_W-1:0]  y,
                                                   input logic [DIST_W-1:0] z);
        logic [DIST_W+1:0] s;
        s = {2'b00, x} + {{(DIST_W+2-LEN_W){1'b0}}, y} + {2'b00, z};
        return (s > {2'b00, DIST_MAX}) ? DIST_MAX : s[DIST_W-1:0];
    endfunction

endpackage

// ===== rtl/apdu_ram.sv =====
// ----------------------------------------------------------------------------
// apdu_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module apdu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/incremental_all_pairs_distance_update_unit.sv =====
// ----------------------------------------------------------------------------
// incremental_all_pairs_distance_update_unit
// Keeps an all-pairs distance matrix and relaxes it when a road is added.
//
// A request is taken when start is high and busy is low. A load request
// (req_type 0) writes one matrix entry in the cycle it is taken and gives
// no result; busy stays low. A road request (req_type 1) lowers the a-b and
// b-a entries, then sweeps all n*n pairs in row-major order through one
// RAM with a single read and a single write port. Each pair takes three
// reads and two compare steps, the second with the write; each row first
// fetches its a and b entries. A road with an endpoint outside the store
// only sums the table, one read and one add step per entry. The result is
// shown for one cycle with done high; it cannot be held off. node_count is
// written through cfg_we/cfg_wdata; the user must do so only while idle,
// the block does not enforce it. Reset sets node_count to 256 and returns
// the sequencer to idle; the matrix is undefined until loaded.
// ----------------------------------------------------------------------------
module incremental_all_pairs_distance_update_unit
    import apdu_pkg::*;
#(
    parameter int MAX_NODES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [7:0]         first_node,
    input  logic [7:0]         second_node,
    input  logic [LEN_W-1:0]   length_value,
    output logic               done,
    output logic [SUM_W-1:0]   total_distance_sum,
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int AW    = 2 * NW;
    localparam int ACC_W = AW + DIST_W;
    localparam int NCW   = (CNT_W > NW + 1) ? CNT_W : NW + 1;

    apdu_state_t state_reg, state_next;

    logic [CNT_W-1:0]  node_count_reg;
    logic [NW-1:0]     i_reg, i_next, j_reg, j_next;
    logic [NW-1:0]     a_reg, a_next, b_reg, b_next, n_m1_reg, n_m1_next;
    logic [LEN_W-1:0]  c_reg, c_next;
    logic [DIST_W-1:0] ia_reg, ia_next, ib_reg, ib_next;
    logic [DIST_W-1:0] dij_reg, dij_next, dbj_reg, dbj_next;
    logic [DIST_W-1:0] daj_reg, daj_next, d1_reg, d1_next;
    logic [ACC_W-1:0]  sum_reg, sum_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [DIST_W-1:0] wr_data, rd_data;

    logic [NCW-1:0]    node_eff;
    logic              accept, ends_in_range;
    logic [DIST_W-1:0] t1, t2, dib_use, daj_use, d2;
    logic [DIST_W-1:0] c_ext;

    apdu_ram #(
        .WIDTH (DIST_W),
        .DEPTH (1 << AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= CNT_W'(256);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        n_m1_reg <= n_m1_next;
        c_reg    <= c_next;
        ia_reg   <= ia_next;
        ib_reg   <= ib_next;
        dij_reg  <= dij_next;
        dbj_reg  <= dbj_next;
        daj_reg  <= daj_next;
        d1_reg   <= d1_next;
        sum_reg  <= sum_next;
    end

    assign accept   = start && !busy;
    assign node_eff = (32'(node_count_reg) > MAX_NODES) ? NCW'(MAX_NODES)
                                                        : NCW'(node_count_reg);
    assign ends_in_range = (32'(first_node) < MAX_NODES) && (32'(second_node) < MAX_NODES);
    assign c_ext = {{(DIST_W-LEN_W){1'b0}}, c_reg};

    // Second relaxation sees the first one's result where it reads the same entry.
    assign t1      = sat_add3(ia_reg, c_reg, dbj_reg);
    assign dib_use = (j_reg == b_reg) ? d1_reg : ib_reg;
    assign daj_use = (i_reg == a_reg) ? d1_reg : daj_reg;
    assign t2      = sat_add3(dib_use, c_reg, daj_use);
    assign d2      = (t2 < d1_reg) ? t2 : d1_reg;

    assign busy               = (state_reg != ST_IDLE);
    assign done               = (state_reg == ST_DONE);
    assign total_distance_sum = SUM_W'(sum_reg >> 1);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        n_m1_next  = n_m1_reg;
        c_next     = c_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        dij_next   = dij_reg;
        dbj_next   = dbj_reg;
        daj_next   = daj_reg;
        d1_next    = d1_reg;
        sum_next   = sum_reg;
        wr_en      = 1'b0;
        wr_addr    = {i_reg, j_reg};
        wr_data    = d2;
        rd_addr    = {i_reg, j_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_type == REQ_LOAD)
                begin
                    wr_en   = ends_in_range;
                    wr_addr = {NW'(first_node), NW'(second_node)};
                    wr_data = {{(DIST_W-LEN_W){1'b0}}, length_value};
                end
                else if (accept)
                begin
                    a_next    = NW'(first_node);
                    b_next    = NW'(second_node);
                    c_next    = length_value;
                    n_m1_next = NW'(node_eff - NCW'(1));
                    i_next    = '0;
                    j_next    = '0;
                    sum_next  = '0;
                    if (!ends_in_range)
                    begin
                        state_next = (node_eff == '0) ? ST_DONE : ST_SRD;
                    end
                    else
                    begin
                        state_next = ST_LAB;
                    end
                end
            end
            ST_LAB:
            begin
                rd_addr    = {a_reg, b_reg};
                state_next = ST_WAB;
            end
            ST_WAB:
            begin
                wr_en      = (c_ext < rd_data);
                wr_addr    = {a_reg, b_reg};
                wr_data    = c_ext;
                state_next = ST_LBA;
            end
            ST_LBA:
            begin
                rd_addr    = {b_reg, a_reg};
                state_next = ST_WBA;
            end
            ST_WBA:
            begin
                wr_en      = (c_ext < rd_data);
                wr_addr    = {b_reg, a_reg};
                wr_data    = c_ext;
                state_next = (node_eff == '0) ? ST_DONE : ST_RIA;
            end
            ST_RIA:
            begin
                rd_addr    = {i_reg, a_reg};
                state_next = ST_RIB;
            end
            ST_RIB:
            begin
                rd_addr    = {i_reg, b_reg};
                ia_next    = rd_data;
                state_next = ST_RIBC;
            end
            ST_RIBC:
            begin
                ib_next    = rd_data;
                state_next = ST_PIJ;
            end
            ST_PIJ:
            begin
                rd_addr    = {i_reg, j_reg};
                state_next = ST_PBJ;
            end
            ST_PBJ:
            begin
                rd_addr    = {b_reg, j_reg};
                dij_next   = rd_data;
                state_next = ST_PAJ;
            end
            ST_PAJ:
            begin
                rd_addr    = {a_reg, j_reg};
                dbj_next   = rd_data;
                state_next = ST_PC1;
            end
            ST_PC1:
            begin
                daj_next   = rd_data;
                d1_next    = (t1 < dij_reg) ? t1 : dij_reg;
                state_next = ST_PC2;
            end
            ST_PC2:
            begin
                wr_en    = 1'b1;
                sum_next = sum_reg + ACC_W'(d2);
                // Keep the row's a and b entries current as the row is rewritten.
                if (j_reg == a_reg)
                begin
                    ia_next = d2;
                end
                if (j_reg == b_reg)
                begin
                    ib_next = d2;
                end
                if (j_reg == n_m1_reg)
                begin
                    j_next = '0;
                    if (i_reg == n_m1_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + NW'(1);
                        state_next = ST_RIA;
                    end
                end
                else
                begin
                    j_next     = j_reg + NW'(1);
                    state_next = ST_PIJ;
                end
            end
            ST_SRD:
            begin
                rd_addr    = {i_reg, j_reg};
                state_next = ST_SACC;
            end
            ST_SACC:
            begin
                sum_next = sum_reg + ACC_W'(rd_data);
                if (j_reg == n_m1_reg)
                begin
                    j_next = '0;
                    if (i_reg == n_m1_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + NW'(1);
                        state_next = ST_SRD;
                    end
                end
                else
                begin
                    j_next     = j_reg + NW'(1);
                    state_next = ST_SRD;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/apdu_checker.sv =====
// ----------------------------------------------------------------------------
// apdu_checker
// Port-level checks on request acceptance and result timing.
// ----------------------------------------------------------------------------
`include "incremental_all_pairs_distance_update_unit_assert.svh"

module apdu_checker
    import apdu_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic req_type,
    input logic done
);

    `APDU_ASSERT_NOW(a_done_while_busy, clk, rst_n, done, busy)
    `APDU_ASSERT_NEXT(a_idle_after_done, clk, rst_n, done, !busy && !done)
    `APDU_ASSERT_NEXT(a_load_no_busy, clk, rst_n, start && !busy && req_type == REQ_LOAD, !busy && !done)
    `APDU_ASSERT_NEXT(a_road_goes_busy, clk, rst_n, start && !busy && req_type == REQ_ROAD, busy)

endmodule

bind incremental_all_pairs_distance_update_unit apdu_checker u_apdu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .done     (done)
);

// ===== verif/distance_sum_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// distance_sum_checker
// Watches the request, result and node count ports of the all-pairs
// distance unit. It keeps its own distance matrix, predicts the half sum
// for every road request and compares each result strobe with it.
// ----------------------------------------------------------------------------
module distance_sum_checker
    import apdu_pkg::*;
#(
    parameter int MAX_NODES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             req_type,
    input  logic [7:0]       first_node,
    input  logic [7:0]       second_node,
    input  logic [LEN_W-1:0] length_value,
    input  logic             done,
    input  logic [SUM_W-1:0] total_distance_sum,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    output int               error_count,
    output int               sums_pending
);

    logic [DIST_W-1:0] dist_matrix [0:MAX_NODES*MAX_NODES-1];
    logic [SUM_W-1:0]  sums_q [$];
    int                nodes_used;

    function automatic logic [DIST_W-1:0] via_road(input logic [DIST_W-1:0] x,
                                                   input logic [LEN_W-1:0]  len,
                                                   input logic [DIST_W-1:0] z);
        logic [DIST_W+1:0] total;
        total = (DIST_W+2)'(x) + (DIST_W+2)'(len) + (DIST_W+2)'(z);
        if (total > (DIST_W+2)'(DIST_MAX))
            return DIST_MAX;
        return total[DIST_W-1:0];
    endfunction

    // Applies one road to the matrix and returns the half sum of the used block.
    function automatic logic [SUM_W-1:0] add_road(input int a, input int b,
                                                  input logic [LEN_W-1:0] len);
        longint            sum;
        logic [DIST_W-1:0] cand;
        int                n;
        sum = 0;
        n = (nodes_used > MAX_NODES) ? MAX_NODES : nodes_used;
        if (DIST_W'(len) < dist_matrix[a*MAX_NODES+b])
            dist_matrix[a*MAX_NODES+b] = DIST_W'(len);
        if (DIST_W'(len) < dist_matrix[b*MAX_NODES+a])
            dist_matrix[b*MAX_NODES+a] = DIST_W'(len);
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                cand = via_road(dist_matrix[i*MAX_NODES+a], len,
                                dist_matrix[b*MAX_NODES+j]);
                if (cand < dist_matrix[i*MAX_NODES+j])
                    dist_matrix[i*MAX_NODES+j] = cand;
                cand = via_road(dist_matrix[i*MAX_NODES+b], len,
                                dist_matrix[a*MAX_NODES+j]);
                if (cand < dist_matrix[i*MAX_NODES+j])
                    dist_matrix[i*MAX_NODES+j] = cand;
                sum += longint'(dist_matrix[i*MAX_NODES+j]);
            end
        end
        return SUM_W'(sum / 2);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_used   <= 256;
            error_count  <= 0;
            sums_pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (sums_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %0d",
                             $time, total_distance_sum);
                    error_count <= error_count + 1;
                end
                else
                begin
                    if (total_distance_sum !== sums_q[0])
                    begin
                        $display("%0t: total_distance_sum expected %0d actual %0d",
                                 $time, sums_q[0], total_distance_sum);
                        error_count <= error_count + 1;
                    end
                    void'(sums_q.pop_front());
                end
            end
            if (cfg_we)
                nodes_used <= int'(cfg_wdata);
            if (start && !busy)
            begin
                if (req_type == REQ_LOAD)
                    dist_matrix[first_node*MAX_NODES+second_node] = DIST_W'(length_value);
                else
                    sums_q.push_back(add_road(first_node, second_node, length_value));
            end
            sums_pending <= sums_q.size();
        end
    end

endmodule

// ===== verif/tb_incremental_all_pairs_distance_update_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_incremental_all_pairs_distance_update_unit
// Loads distance blocks and adds directed and random roads under several
// node counts. The checker beside the unit predicts and compares every
// result.
// ----------------------------------------------------------------------------
module tb_incremental_all_pairs_distance_update_unit;
    import apdu_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             req_type;
    logic [7:0]       first_node;
    logic [7:0]       second_node;
    logic [LEN_W-1:0] length_value;
    logic             done;
    logic [SUM_W-1:0] total_distance_sum;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    int               error_count;
    int               sums_pending;
    bit               no_gaps;
    int               far_node;

    incremental_all_pairs_distance_update_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .first_node(first_node), .second_node(second_node),
        .length_value(length_value), .done(done),
        .total_distance_sum(total_distance_sum),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    distance_sum_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .first_node(first_node), .second_node(second_node),
        .length_value(length_value), .done(done),
        .total_distance_sum(total_distance_sum),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .error_count(error_count), .sums_pending(sums_pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Leaves start high on return, so a following request can go back to back.
    task automatic send_request(input logic kind, input int a, input int b,
                                input int len);
        int gap;
        gap = no_gaps ? 0 : int'($urandom_range(0, 5));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        req_type     <= kind;
        first_node   <= 8'(a);
        second_node  <= 8'(b);
        length_value <= LEN_W'(len);
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sums_pending != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_node_count(input int count);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_W'(count);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic int random_length();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 16'hFFFF;
            2: return int'($urandom_range(0, 15));
            default: return int'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Nodes 0..3, 255 and one random far node are the only ones ever loaded.
    function automatic int pick_node();
        int k;
        k = int'($urandom_range(0, 5));
        if (k < 4)
            return k;
        return (k == 4) ? 255 : far_node;
    endfunction

    initial
    begin
        int small_set [5];
        int count;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = REQ_LOAD;
        first_node   = '0;
        second_node  = '0;
        length_value = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        no_gaps      = 1'b0;
        far_node     = int'($urandom_range(4, 254));
        small_set    = '{0, 1, 2, 3, 255};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part on a four node block plus node 255.
        set_node_count(4);
        foreach (small_set[i])
            foreach (small_set[j])
                send_request(REQ_LOAD, small_set[i], small_set[j], random_length());
        send_request(REQ_LOAD, 0, 1, 16'hFFFF);
        send_request(REQ_LOAD, 1, 0, 0);
        send_request(REQ_ROAD, 0, 1, 0);
        send_request(REQ_ROAD, 2, 2, 5);
        send_request(REQ_ROAD, 1, 3, 16'hFFFF);
        // Endpoint beyond the node count but inside the store.
        send_request(REQ_ROAD, 0, 255, 7);
        send_request(REQ_ROAD, 255, 255, 0);
        set_node_count(0);
        send_request(REQ_ROAD, 3, 0, 1);
        set_node_count(1);
        send_request(REQ_ROAD, 0, 2, 3);

        // Random part on nodes 0..3, 255 and the far node.
        set_node_count(4);
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 6; j++)
                send_request(REQ_LOAD, (i < 4) ? i : ((i == 4) ? 255 : far_node),
                             (j < 4) ? j : ((j == 4) ? 255 : far_node),
                             random_length());
        for (int phase = 0; phase < 5; phase++)
        begin
            count = (phase == 0) ? 4 : ((phase == 1) ? 1 : int'($urandom_range(0, 4)));
            set_node_count(count);
            no_gaps = (phase == 2);
            for (int k = 0; k < 6; k++)
            begin
                if (phase == 3 && k == 3)
                    wait_results_drained();
                if ($urandom_range(0, 3) == 0)
                    send_request(REQ_LOAD, pick_node(), pick_node(), random_length());
                else
                    send_request(REQ_ROAD, pick_node(), pick_node(), random_length());
            end
        end
        no_gaps = 1'b0;

        wait_results_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
